### hdl/tls_pkg.sv
// ----------------------------------------------------------------------------
// tls_pkg
// Widths, latencies, types and helper functions shared by the three-line
// triangle solver.
// ----------------------------------------------------------------------------
`default_nettype none

package tls_pkg;

  localparam int COEF_BITS      = 12;
  localparam int FRAC_BITS      = 16;
  localparam int AREA_FRAC_BITS = 8;

  localparam int STATUS_W = 3;
  localparam int MEET_W   = 40;
  localparam int SIDE_W   = 41;
  localparam int AREA_W   = 58;

  localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_PAR12 = 3'd1;
  localparam logic [STATUS_W-1:0] ST_PAR23 = 3'd2;
  localparam logic [STATUS_W-1:0] ST_PAR13 = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DEGEN = 3'd4;

  // Coefficient places within a line.
  localparam int K_X   = 0;
  localparam int K_Y   = 1;
  localparam int K_RHS = 2;

  // Product places within a pair of lines a and b.
  localparam int P_A0B1 = 0;
  localparam int P_A1B0 = 1;
  localparam int P_A2B1 = 2;
  localparam int P_A1B2 = 3;
  localparam int P_A0B2 = 4;
  localparam int P_A2B0 = 5;

  localparam int PROD_W = 2 * COEF_BITS;
  localparam int DET_W  = PROD_W + 1;
  localparam int DMAG_W = PROD_W;
  localparam int NMAG_W = DMAG_W + FRAC_BITS;
  localparam int QUO_W  = NMAG_W;
  localparam int DTW    = DMAG_W + 1;
  localparam int PT_W   = QUO_W + 1;
  localparam int PTX_W  = PT_W + 1;
  localparam int OP_W   = PT_W;
  localparam int HALF_W = (OP_W + 1) / 2;
  localparam int MW2    = 2 * HALF_W;
  localparam int MW4    = 4 * HALF_W;
  localparam int MUL_W  = 2 * OP_W;
  localparam int SQ_W   = MUL_W + 1;
  localparam int ROOT_W = (SQ_W + 1) / 2;
  localparam int RAD_W  = 2 * ROOT_W;
  localparam int STW    = ROOT_W + 2;
  localparam int SUM_W  = MUL_W + 3;
  localparam int AREA_SH = 2 * FRAC_BITS - AREA_FRAC_BITS + 1;
  localparam int XW     = (SUM_W > AREA_W) ? SUM_W : AREA_W + 1;
  localparam int MEET_EXT_W = PT_W + MEET_W;
  localparam int SIDE_EXT_W = ROOT_W + SIDE_W;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_CNT_W = 3;

  localparam int DIV_LAT  = QUO_W + 2;
  localparam int SQRT_LAT = ROOT_W;
  localparam int CTRL_LEN = DIV_LAT + 4 + SQRT_LAT;
  localparam int PT_DLY   = CTRL_LEN - DIV_LAT;
  localparam int AREA_DLY = SQRT_LAT - 1;

  typedef logic [2:0][2:0][COEF_BITS-1:0] tls_lines_t;

  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic [2:0][DET_W-1:0]     det;
    logic [2:0][DET_W-1:0]     nx;
    logic [2:0][DET_W-1:0]     ny;
  } tls_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic [5:0][MEET_W-1:0]    meet;
    logic [2:0][SIDE_W-1:0]    side;
    logic [AREA_W-1:0]         area;
  } tls_result_t;

  function automatic logic signed [PROD_W-1:0] cmul(logic signed [COEF_BITS-1:0] u,
                                                    logic signed [COEF_BITS-1:0] v);
    return PROD_W'(u) * PROD_W'(v);
  endfunction

  function automatic logic [DMAG_W-1:0] mag_det(logic signed [DET_W-1:0] v);
    logic [DET_W-1:0] n;
    n = v[DET_W-1] ? -v : v;
    return n[DMAG_W-1:0];
  endfunction

  function automatic logic [OP_W-1:0] absdiff(logic signed [PT_W-1:0] a,
                                              logic signed [PT_W-1:0] b);
    logic signed [PTX_W-1:0] ae;
    logic signed [PTX_W-1:0] be;
    logic [PTX_W-1:0] d;
    ae = PTX_W'(a);
    be = PTX_W'(b);
    d = (a >= b) ? ae - be : be - ae;
    return d[OP_W-1:0];
  endfunction

  function automatic logic [OP_W-1:0] absval(logic signed [PT_W-1:0] a);
    logic [PT_W-1:0] d;
    d = a[PT_W-1] ? -a : a;
    return d;
  endfunction

  function automatic logic [MEET_W-1:0] fit_meet(logic signed [PT_W-1:0] v);
    logic signed [MEET_EXT_W-1:0] t;
    t = MEET_EXT_W'(v);
    return t[MEET_W-1:0];
  endfunction

  function automatic logic [SIDE_W-1:0] fit_side(logic [ROOT_W-1:0] v);
    logic [SIDE_EXT_W-1:0] t;
    t = SIDE_EXT_W'(v);
    return t[SIDE_W-1:0];
  endfunction

endpackage

`default_nettype wire

### hdl/tls_front.sv
// ----------------------------------------------------------------------------
// tls_front
// Takes a line triple, forms the coefficient products, then classifies the
// triple and hands determinants and numerators on to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module tls_front import tls_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  tls_lines_t lines,
  output logic       push,
  output tls_item_t  item,
  input  logic       full
);

  logic                         f1_valid;
  logic [2:0][5:0][PROD_W-1:0]  prod;
  logic [2:0]                   qz;
  logic [2:0]                   par;
  logic [2:0]                   dz;

  assign in_ready = !f1_valid || !full;
  assign push     = f1_valid && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else if (in_ready) begin
      f1_valid <= in_valid;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_pair
    localparam int A = (i == 1) ? 1 : 0;
    localparam int B = (i == 0) ? 1 : 2;

    always_ff @(posedge clk) begin
      if (in_valid && in_ready) begin
        prod[i][P_A0B1] <= cmul(lines[A][K_X],   lines[B][K_Y]);
        prod[i][P_A1B0] <= cmul(lines[A][K_Y],   lines[B][K_X]);
        prod[i][P_A2B1] <= cmul(lines[A][K_RHS], lines[B][K_Y]);
        prod[i][P_A1B2] <= cmul(lines[A][K_Y],   lines[B][K_RHS]);
        prod[i][P_A0B2] <= cmul(lines[A][K_X],   lines[B][K_RHS]);
        prod[i][P_A2B0] <= cmul(lines[A][K_RHS], lines[B][K_X]);
        qz[i]           <= (lines[i][K_Y] == '0);
      end
    end

    assign item.det[i] = DET_W'($signed(prod[i][P_A0B1])) - DET_W'($signed(prod[i][P_A1B0]));
    assign item.nx[i]  = DET_W'($signed(prod[i][P_A2B1])) - DET_W'($signed(prod[i][P_A1B2]));
    assign item.ny[i]  = DET_W'($signed(prod[i][P_A0B2])) - DET_W'($signed(prod[i][P_A2B0]));
    assign dz[i]       = (item.det[i] == '0);
    assign par[i]      = (qz[A] == qz[B]) && dz[i];
  end

  always_comb begin
    if (par[0]) begin
      item.status = ST_PAR12;
    end else if (par[1]) begin
      item.status = ST_PAR23;
    end else if (par[2]) begin
      item.status = ST_PAR13;
    end else if (|dz) begin
      item.status = ST_DEGEN;
    end else begin
      item.status = ST_OK;
    end
  end

endmodule

`default_nettype wire

### hdl/tls_fifo.sv
// ----------------------------------------------------------------------------
// tls_fifo
// Short queue of classified triples between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module tls_fifo import tls_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  tls_item_t wr_item,
  output logic      full,
  input  logic      pop,
  output tls_item_t rd_item,
  output logic      empty
);

  tls_item_t               mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_ptr;
  logic [FIFO_PTR_W-1:0]   rd_ptr;
  logic [FIFO_CNT_W-1:0]   count;

  assign full    = (count == FIFO_CNT_W'(FIFO_DEPTH));
  assign empty   = (count == '0);
  assign rd_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

### hdl/tls_div.sv
// ----------------------------------------------------------------------------
// tls_div
// Pipelined signed fixed-point divider, one quotient bit per stage, with the
// quotient truncated toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module tls_div import tls_pkg::*; (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [DET_W-1:0] num,
  input  logic signed [DET_W-1:0] den,
  output logic signed [PT_W-1:0]  quo
);

  logic [DMAG_W-1:0] nmag;
  logic [DMAG_W-1:0] dmag;
  logic              neg;

  logic [DMAG_W-1:0] rem_q [QUO_W];
  logic [NMAG_W-1:0] dvd_q [QUO_W];
  logic [QUO_W-1:0]  quo_q [QUO_W];
  logic [DMAG_W-1:0] den_q [QUO_W];
  logic              neg_q [QUO_W];

  always_ff @(posedge clk) begin
    if (en) begin
      nmag <= mag_det(num);
      dmag <= mag_det(den);
      neg  <= num[DET_W-1] ^ den[DET_W-1];
    end
  end

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    logic [DMAG_W-1:0] rem_i;
    logic [NMAG_W-1:0] dvd_i;
    logic [QUO_W-1:0]  quo_i;
    logic [DMAG_W-1:0] den_i;
    logic              neg_i;
    logic [DTW-1:0]    t;
    logic [DTW-1:0]    diff;

    if (k == 0) begin : g_first
      assign rem_i = '0;
      assign dvd_i = {nmag, {FRAC_BITS{1'b0}}};
      assign quo_i = '0;
      assign den_i = dmag;
      assign neg_i = neg;
    end else begin : g_next
      assign rem_i = rem_q[k-1];
      assign dvd_i = dvd_q[k-1];
      assign quo_i = quo_q[k-1];
      assign den_i = den_q[k-1];
      assign neg_i = neg_q[k-1];
    end

    assign t    = {rem_i, dvd_i[NMAG_W-1]};
    assign diff = t - {1'b0, den_i};

    always_ff @(posedge clk) begin
      if (en) begin
        if (t >= {1'b0, den_i}) begin
          rem_q[k] <= diff[DMAG_W-1:0];
          quo_q[k] <= {quo_i[QUO_W-2:0], 1'b1};
        end else begin
          rem_q[k] <= t[DMAG_W-1:0];
          quo_q[k] <= {quo_i[QUO_W-2:0], 1'b0};
        end
        dvd_q[k] <= {dvd_i[NMAG_W-2:0], 1'b0};
        den_q[k] <= den_i;
        neg_q[k] <= neg_i;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (neg_q[QUO_W-1]) begin
        quo <= PT_W'(0) - {1'b0, quo_q[QUO_W-1]};
      end else begin
        quo <= {1'b0, quo_q[QUO_W-1]};
      end
    end
  end

endmodule

`default_nettype wire

### hdl/tls_mul.sv
// ----------------------------------------------------------------------------
// tls_mul
// Two-stage unsigned multiplier built from four half-width partial products.
// ----------------------------------------------------------------------------
`default_nettype none

module tls_mul import tls_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [OP_W-1:0]  a,
  input  logic [OP_W-1:0]  b,
  output logic [MUL_W-1:0] p
);

  logic [MW2-1:0] a_w;
  logic [MW2-1:0] b_w;
  logic [MW2-1:0] pp00;
  logic [MW2-1:0] pp01;
  logic [MW2-1:0] pp10;
  logic [MW2-1:0] pp11;
  logic [MW4-1:0] s;

  assign a_w = MW2'(a);
  assign b_w = MW2'(b);

  always_ff @(posedge clk) begin
    if (en) begin
      pp00 <= a_w[HALF_W-1:0]   * b_w[HALF_W-1:0];
      pp01 <= a_w[HALF_W-1:0]   * b_w[MW2-1:HALF_W];
      pp10 <= a_w[MW2-1:HALF_W] * b_w[HALF_W-1:0];
      pp11 <= a_w[MW2-1:HALF_W] * b_w[MW2-1:HALF_W];
    end
  end

  assign s = {pp11, pp00} + ((MW4'(pp01) + MW4'(pp10)) << HALF_W);

  always_ff @(posedge clk) begin
    if (en) begin
      p <= s[MUL_W-1:0];
    end
  end

endmodule

`default_nettype wire

### hdl/tls_sqrt.sv
// ----------------------------------------------------------------------------
// tls_sqrt
// Pipelined integer square root, one root bit per stage, giving the floor.
// ----------------------------------------------------------------------------
`default_nettype none

module tls_sqrt import tls_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [SQ_W-1:0]   rad,
  output logic [ROOT_W-1:0] root
);

  logic [STW-1:0]    rem_q  [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];
  logic [RAD_W-1:0]  rad_q  [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic [STW-1:0]    rem_i;
    logic [ROOT_W-1:0] root_i;
    logic [RAD_W-1:0]  rad_i;
    logic [STW-1:0]    t;
    logic [STW-1:0]    trial;

    if (k == 0) begin : g_first
      assign rem_i  = '0;
      assign root_i = '0;
      assign rad_i  = RAD_W'(rad);
    end else begin : g_next
      assign rem_i  = rem_q[k-1];
      assign root_i = root_q[k-1];
      assign rad_i  = rad_q[k-1];
    end

    assign t     = {rem_i[STW-3:0], rad_i[RAD_W-1 -: 2]};
    assign trial = {root_i, 2'b01};

    always_ff @(posedge clk) begin
      if (en) begin
        if (t >= trial) begin
          rem_q[k]  <= t - trial;
          root_q[k] <= {root_i[ROOT_W-2:0], 1'b1};
        end else begin
          rem_q[k]  <= t;
          root_q[k] <= {root_i[ROOT_W-2:0], 1'b0};
        end
        rad_q[k] <= {rad_i[RAD_W-3:0], 2'b00};
      end
    end
  end

  assign root = root_q[ROOT_W-1];

endmodule

`default_nettype wire

### hdl/tls_back.sv
// ----------------------------------------------------------------------------
// tls_back
// Back pipeline: intersections, side lengths and area, with the result
// register at its end. The whole pipeline holds while a result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module tls_back import tls_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        head_valid,
  input  tls_item_t   head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output tls_result_t result
);

  logic                    en;
  logic [CTRL_LEN-1:0]     vld;
  logic [STATUS_W-1:0]     st [CTRL_LEN];

  logic signed [PT_W-1:0]  qx [3];
  logic signed [PT_W-1:0]  qy [3];

  logic [OP_W-1:0]         dxm [3];
  logic [OP_W-1:0]         dym [3];
  logic [OP_W-1:0]         axm [3];
  logic [OP_W-1:0]         aym [3];
  logic [2:0]              tneg_e;
  logic [2:0]              tneg_m1;
  logic [2:0]              tneg_m2;

  logic [MUL_W-1:0]        psx [3];
  logic [MUL_W-1:0]        psy [3];
  logic [MUL_W-1:0]        pam [3];

  logic [SQ_W-1:0]         sq [3];
  logic signed [SUM_W-1:0] term [3];
  logic signed [SUM_W-1:0] asum;
  logic [SUM_W-1:0]        amag;
  logic [XW-1:0]           ashift;
  logic [AREA_W-1:0]       area_u;
  logic [AREA_W-1:0]       ad [AREA_DLY];

  logic [ROOT_W-1:0]       root [3];
  logic [5:0][PT_W-1:0]    pd [PT_DLY];

  assign en  = !out_valid || out_ready;
  assign pop = head_valid && en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[CTRL_LEN-2:0], head_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= head.status;
      for (int k = 1; k < CTRL_LEN; k++) begin
        st[k] <= st[k-1];
      end
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_div
    tls_div u_div_x (
      .clk (clk),
      .en  (en),
      .num ($signed(head.nx[i])),
      .den ($signed(head.det[i])),
      .quo (qx[i])
    );
    tls_div u_div_y (
      .clk (clk),
      .en  (en),
      .num ($signed(head.ny[i])),
      .den ($signed(head.det[i])),
      .quo (qy[i])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dxm[0]    <= absdiff(qx[0], qx[1]);
      dym[0]    <= absdiff(qy[0], qy[1]);
      dxm[1]    <= absdiff(qx[1], qx[2]);
      dym[1]    <= absdiff(qy[1], qy[2]);
      dxm[2]    <= absdiff(qx[0], qx[2]);
      dym[2]    <= absdiff(qy[0], qy[2]);
      axm[0]    <= absval(qx[0]);
      aym[0]    <= absdiff(qy[1], qy[2]);
      tneg_e[0] <= qx[0][PT_W-1] ^ (qy[1] < qy[2]);
      axm[1]    <= absval(qx[2]);
      aym[1]    <= absdiff(qy[0], qy[1]);
      tneg_e[1] <= qx[2][PT_W-1] ^ (qy[0] < qy[1]);
      axm[2]    <= absval(qx[1]);
      aym[2]    <= absdiff(qy[2], qy[0]);
      tneg_e[2] <= qx[1][PT_W-1] ^ (qy[2] < qy[0]);
      tneg_m1   <= tneg_e;
      tneg_m2   <= tneg_m1;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_mul
    tls_mul u_mul_dx (.clk(clk), .en(en), .a(dxm[i]), .b(dxm[i]), .p(psx[i]));
    tls_mul u_mul_dy (.clk(clk), .en(en), .a(dym[i]), .b(dym[i]), .p(psy[i]));
    tls_mul u_mul_ar (.clk(clk), .en(en), .a(axm[i]), .b(aym[i]), .p(pam[i]));

    always_ff @(posedge clk) begin
      if (en) begin
        sq[i] <= SQ_W'(psx[i]) + SQ_W'(psy[i]);
        if (tneg_m2[i]) begin
          term[i] <= SUM_W'(0) - SUM_W'(pam[i]);
        end else begin
          term[i] <= SUM_W'(pam[i]);
        end
      end
    end

    tls_sqrt u_sqrt (.clk(clk), .en(en), .rad(sq[i]), .root(root[i]));
  end

  always_comb begin
    amag   = asum[SUM_W-1] ? -asum : asum;
    ashift = XW'(amag) >> AREA_SH;
    area_u = (|ashift[XW-1:AREA_W]) ? '1 : ashift[AREA_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      asum  <= term[0] + term[1] + term[2];
      ad[0] <= area_u;
      for (int k = 1; k < AREA_DLY; k++) begin
        ad[k] <= ad[k-1];
      end
      for (int i = 0; i < 3; i++) begin
        pd[0][2*i]   <= qx[i];
        pd[0][2*i+1] <= qy[i];
      end
      for (int k = 1; k < PT_DLY; k++) begin
        pd[k] <= pd[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[CTRL_LEN-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.status <= st[CTRL_LEN-1];
      for (int i = 0; i < 6; i++) begin
        result.meet[i] <= (st[CTRL_LEN-1] == ST_OK) ? fit_meet(pd[PT_DLY-1][i]) : '0;
      end
      for (int i = 0; i < 3; i++) begin
        result.side[i] <= (st[CTRL_LEN-1] == ST_OK) ? fit_side(root[i]) : '0;
      end
      result.area <= (st[CTRL_LEN-1] == ST_OK) ? ad[AREA_DLY-1] : '0;
    end
  end

endmodule

`default_nettype wire

### hdl/three_line_triangle_solver.sv
// ----------------------------------------------------------------------------
// three_line_triangle_solver
// Intersections, side lengths and area of the triangle spanned by three lines.
// ----------------------------------------------------------------------------
// The block takes one word of three lines per clock cycle while in_ready is
// high and returns one result word per input word, in order. A word passes
// through the product stage and the four-entry queue, then through the
// 40-stage divider pipeline and the 42-stage square root pipeline of the
// back end. While a result waits on the output, the back end holds and the
// queue goes on taking words.
`default_nettype none

module three_line_triangle_solver import tls_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [COEF_BITS-1:0] line1_x_coef,
  input  logic signed [COEF_BITS-1:0] line1_y_coef,
  input  logic signed [COEF_BITS-1:0] line1_rhs,
  input  logic signed [COEF_BITS-1:0] line2_x_coef,
  input  logic signed [COEF_BITS-1:0] line2_y_coef,
  input  logic signed [COEF_BITS-1:0] line2_rhs,
  input  logic signed [COEF_BITS-1:0] line3_x_coef,
  input  logic signed [COEF_BITS-1:0] line3_y_coef,
  input  logic signed [COEF_BITS-1:0] line3_rhs,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [STATUS_W-1:0]         status,
  output logic signed [MEET_W-1:0]    meet12_x,
  output logic signed [MEET_W-1:0]    meet12_y,
  output logic signed [MEET_W-1:0]    meet23_x,
  output logic signed [MEET_W-1:0]    meet23_y,
  output logic signed [MEET_W-1:0]    meet13_x,
  output logic signed [MEET_W-1:0]    meet13_y,
  output logic [SIDE_W-1:0]           side_12_23,
  output logic [SIDE_W-1:0]           side_23_13,
  output logic [SIDE_W-1:0]           side_12_13,
  output logic [AREA_W-1:0]           tri_area
);

  tls_lines_t  lines;
  tls_item_t   wr_item;
  tls_item_t   rd_item;
  tls_result_t result;
  logic        push;
  logic        full;
  logic        pop;
  logic        empty;

  assign lines[0][K_X]   = line1_x_coef;
  assign lines[0][K_Y]   = line1_y_coef;
  assign lines[0][K_RHS] = line1_rhs;
  assign lines[1][K_X]   = line2_x_coef;
  assign lines[1][K_Y]   = line2_y_coef;
  assign lines[1][K_RHS] = line2_rhs;
  assign lines[2][K_X]   = line3_x_coef;
  assign lines[2][K_Y]   = line3_y_coef;
  assign lines[2][K_RHS] = line3_rhs;

  tls_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .lines    (lines),
    .push     (push),
    .item     (wr_item),
    .full     (full)
  );

  tls_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_item (wr_item),
    .full    (full),
    .pop     (pop),
    .rd_item (rd_item),
    .empty   (empty)
  );

  tls_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (!empty),
    .head       (rd_item),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .result     (result)
  );

  assign status     = result.status;
  assign meet12_x   = result.meet[0];
  assign meet12_y   = result.meet[1];
  assign meet23_x   = result.meet[2];
  assign meet23_y   = result.meet[3];
  assign meet13_x   = result.meet[4];
  assign meet13_y   = result.meet[5];
  assign side_12_23 = result.side[0];
  assign side_23_13 = result.side[1];
  assign side_12_13 = result.side[2];
  assign tri_area   = result.area;

endmodule

`default_nettype wire
